// ===== rtl/core/bhmf_pkg.sv =====
// ============================================================================
// bhmf_pkg: shared definitions for the byte histogram mode finder
// Command codes, field widths, default sizes and the sequencer state type.
// ============================================================================
package bhmf_pkg;

  localparam int unsigned SYMBOL_W        = 8;
  localparam int unsigned MAX_COUNT_W     = 32;
  localparam int unsigned SYMBOL_COUNT_DEF = 256;
  localparam int unsigned COUNT_WIDTH_DEF  = 32;

  localparam logic [SYMBOL_W-1:0] CODE_REPORT = 8'd48;
  localparam logic [SYMBOL_W-1:0] CODE_ENTER  = 8'd10;
  localparam logic [SYMBOL_W-1:0] CODE_ESCAPE = 8'd27;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

endpackage

// ===== rtl/core/byte_histogram_mode_finder.sv =====
// ============================================================================
// byte_histogram_mode_finder: byte histogram with mode report
// Counts bytes in a counter memory and reports the most frequent byte on '0'.
// ============================================================================
// Requests enter on start/symbol and are taken when start is high and busy is
// low. Ordinary bytes are counted by a read-modify-write of the counter memory
// (a registered read, then the write of the incremented count), with the last
// written entry forwarded, so one byte can be taken every cycle while busy is
// low. Bytes 10 and 27, and bytes at or above SYMBOL_COUNT, are dropped without
// effect. The byte '0' (48) starts a report: the block raises busy and walks
// the memory one entry per cycle, reading each counter and writing it back as
// zero. busy stays high through the scan and drain states after the report is
// taken; done pulses for one cycle in the cycle in which busy falls, with
// max_count and max_symbol registered then and held until the next result.
// SYMBOL_COUNT sets the scan length. A new request may be taken in the cycle
// done is high. Results cannot be held off by the receiver.
// After reset the block clears the counter memory first, holding busy high
// until every entry is written to zero, before the first request is taken.
// ============================================================================
module byte_histogram_mode_finder #(
  parameter int unsigned SYMBOL_COUNT = bhmf_pkg::SYMBOL_COUNT_DEF,
  parameter int unsigned COUNT_WIDTH  = bhmf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [bhmf_pkg::SYMBOL_W-1:0]      symbol,
  output logic                               busy,
  output logic                               done,
  output logic [bhmf_pkg::MAX_COUNT_W-1:0]   max_count,
  output logic [bhmf_pkg::SYMBOL_W-1:0]      max_symbol
);
  import bhmf_pkg::*;

  localparam int unsigned IDX_W = $clog2(SYMBOL_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SYMBOL_COUNT - 1);

  state_t state, state_next;

  logic [IDX_W-1:0]       idx;
  logic                   s1_valid;
  logic [IDX_W-1:0]       s1_sym;
  logic                   fwd_valid;
  logic [IDX_W-1:0]       fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_data;
  logic                   cmp_valid;
  logic [IDX_W-1:0]       cmp_idx;
  logic [COUNT_WIDTH-1:0] best;
  logic [IDX_W-1:0]       best_sym;

  logic [COUNT_WIDTH-1:0] counts_mem [SYMBOL_COUNT];
  logic [COUNT_WIDTH-1:0] rdata;
  logic [IDX_W-1:0]       mem_raddr;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  logic                   accept;
  logic                   is_report;
  logic                   is_counted;
  logic [COUNT_WIDTH-1:0] cur_count;
  logic [COUNT_WIDTH-1:0] inc_count;
  logic [COUNT_WIDTH-1:0] best_next;
  logic [IDX_W-1:0]       best_sym_next;
  logic [MAX_COUNT_W-1:0] best_clip;

  assign accept    = start && !busy;
  assign is_report = (symbol == CODE_REPORT);
  assign is_counted = !is_report && (symbol != CODE_ENTER) && (symbol != CODE_ESCAPE) &&
                      ({1'b0, symbol} < (SYMBOL_W + 1)'(SYMBOL_COUNT));

  // The entry written at the previous edge is not yet visible in rdata.
  assign cur_count = (fwd_valid && fwd_addr == s1_sym) ? fwd_data : rdata;
  assign inc_count = (&cur_count) ? cur_count : cur_count + COUNT_WIDTH'(1);

  // Strictly greater keeps the lowest byte on ties.
  always_comb begin
    best_next     = best;
    best_sym_next = best_sym;
    if (cmp_valid && rdata > best) begin
      best_next     = rdata;
      best_sym_next = cmp_idx;
    end
  end

  generate
    if (COUNT_WIDTH > MAX_COUNT_W) begin : g_clip
      assign best_clip = (|best_next[COUNT_WIDTH-1:MAX_COUNT_W]) ? '1
                                                                 : best_next[MAX_COUNT_W-1:0];
    end else begin : g_extend
      assign best_clip = MAX_COUNT_W'(best_next);
    end
  endgenerate

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (idx == IDX_LAST) state_next = ST_IDLE;
      ST_IDLE:  if (accept && is_report) state_next = ST_SCAN;
      ST_SCAN:  if (idx == IDX_LAST) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Outputs and memory controls.
  always_comb begin
    busy      = 1'b1;
    mem_raddr = idx;
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = '0;
    case (state)
      ST_CLEAR, ST_SCAN: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        busy      = 1'b0;
        mem_raddr = symbol[IDX_W-1:0];
        mem_we    = s1_valid;
        mem_waddr = s1_sym;
        mem_wdata = inc_count;
      end
      ST_DRAIN: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= counts_mem[mem_raddr];
    if (mem_we) begin
      counts_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      idx       <= '0;
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      cmp_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      s1_valid  <= accept && is_counted;
      cmp_valid <= (state == ST_SCAN);
      done      <= (state == ST_DRAIN);
      if (state == ST_CLEAR || state == ST_SCAN) begin
        idx <= (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
      end
      if (mem_we) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_sym  <= symbol[IDX_W-1:0];
    cmp_idx <= idx;
    if (mem_we) begin
      fwd_addr <= mem_waddr;
      fwd_data <= mem_wdata;
    end
    if (accept && is_report) begin
      best     <= '0;
      best_sym <= '0;
    end else begin
      best     <= best_next;
      best_sym <= best_sym_next;
    end
    if (state == ST_DRAIN) begin
      max_count  <= best_clip;
      max_symbol <= SYMBOL_W'(best_sym_next);
    end
  end

  // A report request always starts the scan in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (accept && is_report) |=> (state == ST_SCAN))
    else $error("report request did not start the scan");

  // A result only follows the final compare cycle of a scan.
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_DRAIN))
    else $error("result strobe outside a report");

  // An empty histogram reports byte zero.
  assert property (@(posedge clk) disable iff (rst)
    (done && max_count == '0) |-> (max_symbol == '0))
    else $error("nonzero byte reported with zero count");

  // Counting writes and scan compares never share the read data.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !cmp_valid && (state == ST_IDLE || state == ST_SCAN))
    else $error("counter update overlaps the scan");

  // No request is taken while memory is being cleared or scanned.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR || state == ST_SCAN) |-> busy)
    else $error("block not busy during memory sweep");

endmodule
